FILE: hdl/cait_pkg.sv
// Shared types, codes and helpers for the card ID allowlist table.
`timescale 1ns / 1ps

package cait_pkg;

  localparam int IdW     = 40;
  localparam int StatusW = 3;
  localparam int SlotW   = 7;
  localparam int CountW  = 8;

  localparam logic [IdW-1:0] EMPTY_ID = {IdW{1'b1}};

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [StatusW-1:0] STAT_STORED    = 3'd0;
  localparam logic [StatusW-1:0] STAT_PRESENT   = 3'd1;
  localparam logic [StatusW-1:0] STAT_FULL      = 3'd2;
  localparam logic [StatusW-1:0] STAT_DELETED   = 3'd3;
  localparam logic [StatusW-1:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [StatusW-1:0] STAT_CLEARED   = 3'd5;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic done;
    logic free_found;
    logic match_found;
  } scan_stat_t;

  function automatic logic has_ff_byte(input logic [IdW-1:0] v);
    logic r;
    r = 1'b0;
    for (int b = 0; b < IdW / 8; b++) begin
      if (v[8*b +: 8] == 8'hFF) begin
        r = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/card_id_allowlist_table_top.sv
// Top level of the card ID allowlist table: control sequencer, table memory and result register.
//
// The input channel (s_tvalid, s_tready, s_tdata) carries one command item:
// insert a card ID, delete a card ID, or clear the whole table. Operation
// code 3 is accepted and dropped without a result. Every other item gives
// one result item on the output channel (m_tvalid, m_tready, m_tdata) with
// a status, the slot that was written or emptied, and the number of slots
// holding a complete ID, saturated at 255.
// Insert and delete read every slot of the table memory once, one slot per
// cycle through its single read port; the decision and any table write
// follow the scan, then the result goes to the output register. Clear
// writes every slot once. One item is processed at a time.
// After reset the block sweeps every slot of the table to empty with
// s_tready low. A finished result waits in the output register while
// m_tready is low, and the next item may be accepted meanwhile; it holds
// its own result until the output register is free.
`timescale 1ns / 1ps

module card_id_allowlist_table_top
  import cait_pkg::*;
#(
  parameter int SLOTS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // operation [1:0], card_id [41:2], zero [47:42]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status [2:0], slot [9:3], valid_count [17:10], zero [23:18]
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  state_t state;
  state_t state_next;

  logic [AW-1:0]      addr;
  logic               issuing;
  logic               clr_op;
  logic [1:0]         op;
  logic [IdW-1:0]     op_id;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [StatusW-1:0] res_status;
  logic [SlotW-1:0]   res_slot;
  logic [CountW-1:0]  count_sat;

  logic [StatusW-1:0] dec_status;
  logic               dec_we;
  logic [AW-1:0]      dec_slot;
  logic [IdW-1:0]     dec_data;
  logic [SlotW-1:0]   dec_slot_out;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [IdW-1:0]     ram_wdata;
  logic [IdW-1:0]     ram_rdata;

  scan_stat_t         scan_stat;
  logic [AW-1:0]      free_slot;
  logic [AW-1:0]      match_slot;

  logic               accept;
  logic               out_load;
  logic [1:0]         in_op;
  logic [IdW-1:0]     in_id;

  assign in_op  = s_tdata[1:0];
  assign in_id  = s_tdata[41:2];
  assign accept = s_tvalid & s_tready;

  cait_ram #(
    .WIDTH(IdW),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  cait_scan #(
    .SLOTS(SLOTS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .issue     (issuing),
    .issue_last(addr == LAST),
    .issue_addr(addr),
    .rd_data   (ram_rdata),
    .key       (op_id),
    .stat      (scan_stat),
    .free_slot (free_slot),
    .match_slot(match_slot)
  );

  always_comb begin
    dec_status = STAT_NOT_FOUND;
    dec_we     = 1'b0;
    dec_slot   = match_slot;
    dec_data   = EMPTY_ID;
    count_next = count;
    if (op == OP_INSERT) begin
      dec_slot = free_slot;
      dec_data = op_id;
      if (!scan_stat.free_found) begin
        dec_status = STAT_FULL;
      end else if (scan_stat.match_found) begin
        dec_status = STAT_PRESENT;
      end else begin
        dec_status = STAT_STORED;
        dec_we     = 1'b1;
        if (!has_ff_byte(op_id)) begin
          count_next = count + CW'(1);
        end
      end
    end else if (scan_stat.match_found) begin
      dec_status = STAT_DELETED;
      dec_we     = 1'b1;
      if (!has_ff_byte(op_id)) begin
        count_next = count - CW'(1);
      end
    end
    dec_slot_out = dec_we ? SlotW'(dec_slot) : '0;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = EMPTY_ID;
    if (state == S_SWEEP) begin
      ram_we = 1'b1;
    end else if (state == S_DECIDE) begin
      ram_we    = dec_we;
      ram_waddr = dec_slot;
      ram_wdata = dec_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_SWEEP: begin
        if (addr == LAST) begin
          state_next = clr_op ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (in_op)
            OP_INSERT, OP_DELETE: state_next = S_SCAN;
            OP_CLEAR:             state_next = S_SWEEP;
            default:              state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr    <= '0;
      issuing <= 1'b0;
      clr_op  <= 1'b0;
      count   <= '0;
    end else begin
      if (accept) begin
        addr    <= '0;
        issuing <= in_op inside {OP_INSERT, OP_DELETE};
        clr_op  <= (in_op == OP_CLEAR);
        if (in_op == OP_CLEAR) begin
          count <= '0;
        end
      end else if (state == S_SWEEP || issuing) begin
        if (addr == LAST) begin
          issuing <= 1'b0;
        end else begin
          addr <= addr + AW'(1);
        end
      end
      if (state == S_DECIDE) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= in_op;
      op_id <= in_id;
    end
    if (state == S_DECIDE) begin
      res_status <= dec_status;
      res_slot   <= dec_slot_out;
    end else if (state == S_SWEEP && addr == LAST) begin
      res_status <= STAT_CLEARED;
      res_slot   <= '0;
    end
  end

  always_comb begin
    if (count > CW'(255)) begin
      count_sat = 8'hFF;
    end else begin
      count_sat = CountW'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, count_sat, res_slot, res_status};
    end
  end

endmodule

FILE: hdl/cait_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module cait_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/cait_scan.sv
// Scan unit: compares each slot read from the table and tracks the lowest free and matching slots.
`timescale 1ns / 1ps

module cait_scan
  import cait_pkg::*;
#(
  parameter int SLOTS = 128
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     issue,
  input  logic                     issue_last,
  input  logic [$clog2(SLOTS)-1:0] issue_addr,
  input  logic [IdW-1:0]           rd_data,
  input  logic [IdW-1:0]           key,
  output scan_stat_t               stat,
  output logic [$clog2(SLOTS)-1:0] free_slot,
  output logic [$clog2(SLOTS)-1:0] match_slot
);

  localparam int AW = $clog2(SLOTS);

  logic          cmp_valid;
  logic          cmp_last;
  logic [AW-1:0] cmp_addr;
  logic          free_found;
  logic          match_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid   <= 1'b0;
      cmp_last    <= 1'b0;
      free_found  <= 1'b0;
      match_found <= 1'b0;
    end else begin
      cmp_valid <= issue;
      cmp_last  <= issue & issue_last;
      if (start) begin
        free_found  <= 1'b0;
        match_found <= 1'b0;
      end else if (cmp_valid) begin
        if (!free_found && rd_data == EMPTY_ID) begin
          free_found <= 1'b1;
        end
        if (!match_found && rd_data == key) begin
          match_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr <= issue_addr;
    if (cmp_valid && !free_found && rd_data == EMPTY_ID) begin
      free_slot <= cmp_addr;
    end
    if (cmp_valid && !match_found && rd_data == key) begin
      match_slot <= cmp_addr;
    end
  end

  assign stat.done        = cmp_valid & cmp_last;
  assign stat.free_found  = free_found;
  assign stat.match_found = match_found;

endmodule

FILE: tb/card_id_allowlist_table_top_test.sv
// Self-checking testbench for the card ID allowlist table: directed rows, then random fill and drain traffic.
`timescale 1ns / 1ps

module card_id_allowlist_table_top_test;
  import cait_pkg::*;

  localparam int SLOTS = 128;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 900;
  localparam int PAUSE_AT = 450;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 2000;
  localparam int FULL_EXTRA = 40;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
    logic [CountW-1:0]  count;
  } result_t;

  typedef struct packed {
    logic [1:0]     op;
    logic [IdW-1:0] id;
    bit             typed;
    result_t        want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  logic [IdW-1:0] card_mem [SLOTS];
  result_t        pending_results [$];
  row_t           rows [$];
  result_t        front;
  int             errors = 0;
  int             results_seen = 0;
  int             burst_left = 0;

  card_id_allowlist_table_top #(.SLOTS(SLOTS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit complete_id(input logic [IdW-1:0] v);
    for (int b = 0; b < IdW / 8; b++) begin
      if (v[8*b +: 8] == 8'hFF) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic int occupied();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (card_mem[i] != EMPTY_ID) begin
        n++;
      end
    end
    return n;
  endfunction

  // Updates the table copy and returns 1 when the command produces a result.
  function automatic bit apply_command(input logic [1:0] op, input logic [IdW-1:0] id,
                                       output result_t r);
    int free_at;
    int n;
    bit hit;
    r = '0;
    free_at = -1;
    hit = 1'b0;
    case (op)
      OP_INSERT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (free_at < 0 && card_mem[i] == EMPTY_ID) begin
            free_at = i;
          end
          if (card_mem[i] == id) begin
            hit = 1'b1;
          end
        end
        if (free_at < 0) begin
          r.status = STAT_FULL;
        end else if (hit) begin
          r.status = STAT_PRESENT;
        end else begin
          card_mem[free_at] = id;
          r.status = STAT_STORED;
          r.slot = SlotW'(free_at);
        end
      end
      OP_DELETE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (free_at < 0 && card_mem[i] == id) begin
            free_at = i;
          end
        end
        if (free_at < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          card_mem[free_at] = EMPTY_ID;
          r.status = STAT_DELETED;
          r.slot = SlotW'(free_at);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          card_mem[i] = EMPTY_ID;
        end
        r.status = STAT_CLEARED;
      end
      default: begin
        return 1'b0;
      end
    endcase
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (complete_id(card_mem[i]) && n < 255) begin
        n++;
      end
    end
    r.count = CountW'(n);
    return 1'b1;
  endfunction

  function automatic logic [IdW-1:0] pick_card(input int reuse_pct);
    logic [63:0] raw;
    int used [$];
    int r;
    raw = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 4) begin
      return EMPTY_ID;
    end
    if (r < 12) begin
      raw[8*$urandom_range(0, 4) +: 8] = 8'hFF;
      return raw[IdW-1:0];
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (card_mem[i] != EMPTY_ID) begin
        used.push_back(i);
      end
    end
    if (used.size() > 0 && $urandom_range(0, 99) < reuse_pct) begin
      return card_mem[used[$urandom_range(0, used.size() - 1)]];
    end
    return raw[IdW-1:0];
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [IdW-1:0] id,
                                  input bit typed, input logic [StatusW-1:0] st,
                                  input int sl, input int cnt);
    row_t w;
    w.op = op;
    w.id = id;
    w.typed = typed;
    w.want.status = st;
    w.want.slot = SlotW'(sl);
    w.want.count = CountW'(cnt);
    rows.push_back(w);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Called at a falling edge; inserts a random gap, which may be zero, whenever a burst runs out.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic offer(input logic [1:0] op, input logic [IdW-1:0] id, input bit typed,
                       input result_t want);
    result_t r;
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, id, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (apply_command(op, id, r)) begin
      pending_results.push_back(typed ? want : r);
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with no expectation: %h", m_tdata);
        errors++;
      end else begin
        front = pending_results.pop_front();
        check_field("status", front.status, m_tdata[2:0]);
        check_field("slot", front.slot, m_tdata[9:3]);
        check_field("valid_count", front.count, m_tdata[17:10]);
      end
    end
  end

  initial begin : sink
    int mode;
    int span_left;
    bit held;
    m_tready = 1'b0;
    mode = 0;
    span_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (span_left == 0) begin
        mode = $urandom_range(0, 3);
        span_left = $urandom_range(20, 300);
      end
      span_left--;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        2: m_tready <= ($urandom_range(0, 7) == 0);
        default: m_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  initial begin : source
    logic [1:0]     op;
    logic [IdW-1:0] id;
    int             r;
    int             done_items;
    int             extra;
    int             n;
    bit             fill;
    bit             paused;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    for (int i = 0; i < SLOTS; i++) begin
      card_mem[i] = EMPTY_ID;
    end

    add_row(OP_INSERT, 40'h00_0000_0000, 1, STAT_STORED,    0, 1);
    add_row(OP_INSERT, 40'hFF_FFFF_FFFF, 1, STAT_PRESENT,   0, 1);
    add_row(OP_INSERT, 40'h00_0000_0000, 0, STAT_STORED,    0, 0);
    add_row(OP_INSERT, 40'hFF_FFFF_FFFE, 0, STAT_STORED,    0, 0);
    add_row(OP_INSERT, 40'hFE_FEFE_FEFE, 1, STAT_STORED,    2, 2);
    add_row(OP_DELETE, 40'hFF_FFFF_FFFF, 1, STAT_DELETED,   3, 2);
    add_row(OP_DELETE, 40'h12_3456_789A, 1, STAT_NOT_FOUND, 0, 2);
    add_row(OP_UNUSED, 40'h55_5555_5555, 0, STAT_STORED,    0, 0);
    add_row(OP_DELETE, 40'h00_0000_0000, 0, STAT_STORED,    0, 0);
    add_row(OP_INSERT, 40'hAA_AAAA_AAAA, 0, STAT_STORED,    0, 0);
    add_row(OP_INSERT, 40'h55_5555_5555, 0, STAT_STORED,    0, 0);
    add_row(OP_DELETE, 40'hFF_FFFF_FFFE, 0, STAT_STORED,    0, 0);
    add_row(OP_CLEAR,  40'hFF_FFFF_FFFF, 1, STAT_CLEARED,   0, 0);
    add_row(OP_DELETE, 40'hAA_AAAA_AAAA, 1, STAT_NOT_FOUND, 0, 0);
    add_row(OP_INSERT, 40'h00_FF00_FF00, 0, STAT_STORED,    0, 0);
    add_row(OP_INSERT, 40'h00_0000_0001, 0, STAT_STORED,    0, 0);
    add_row(OP_UNUSED, 40'hFF_FFFF_FFFF, 0, STAT_STORED,    0, 0);
    add_row(OP_INSERT, 40'h00_0000_0001, 0, STAT_STORED,    0, 0);
    add_row(OP_DELETE, 40'h00_0000_0001, 0, STAT_STORED,    0, 0);
    add_row(OP_CLEAR,  40'h00_0000_0000, 1, STAT_CLEARED,   0, 0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      pace();
      offer(rows[k].op, rows[k].id, rows[k].typed, rows[k].want);
    end

    // Random traffic alternates between filling the table up to full and draining it.
    fill = 1'b1;
    paused = 1'b0;
    extra = 0;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (!paused && done_items == PAUSE_AT) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
        op = OP_UNUSED;
      end else if (!fill && r < 4) begin
        op = OP_CLEAR;
      end else if (fill) begin
        op = (r < 90) ? OP_INSERT : OP_DELETE;
      end else begin
        op = (r < 88) ? OP_DELETE : OP_INSERT;
      end
      id = pick_card(fill ? 25 : 85);
      pace();
      offer(op, id, 1'b0, '0);
      if (op != OP_UNUSED) begin
        done_items++;
      end
      n = occupied();
      if (fill && n == SLOTS) begin
        extra++;
      end
      if (fill && extra >= FULL_EXTRA) begin
        fill = 1'b0;
        extra = 0;
      end else if (!fill && n <= 3) begin
        fill = 1'b1;
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
